// ===== hw/rtl/twbr_pkg.sv =====
// ----------------------------------------------------------------------------
// twbr_pkg
// Shared types and constants of the time warp bilinear resampler.
// ----------------------------------------------------------------------------
package twbr_pkg;

  localparam int MaxWidth   = 256;
  localparam int MaxHeight  = 256;
  localparam int MaxPoints  = 32;
  localparam int XW         = $clog2(MaxWidth);
  localparam int YW         = $clog2(MaxHeight);
  localparam int PW         = $clog2(MaxPoints);
  localparam int BankDepth  = (MaxWidth / 2) * (MaxHeight / 2);
  localparam int BankAw     = $clog2(BankDepth);

  typedef enum logic [1:0] {
    OP_WR_PIXEL = 2'd0,
    OP_WR_POINT = 2'd1,
    OP_QUERY    = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_PSTEP  = 3'd2,
    REG_LSTEP  = 3'd3,
    REG_NPTS   = 3'd4,
    REG_BIDIR  = 3'd5,
    REG_FILL   = 3'd6,
    REG_SPARE  = 3'd7
  } reg_t;

  typedef struct packed {
    logic [8:0]  width;
    logic [8:0]  height;
    logic [31:0] pixel_step;
    logic [31:0] line_step;
    logic [5:0]  point_count;
    logic        bidir;
    logic        fill;
  } cfg_t;

  // one query handed from the displacement stage to the sampler
  typedef struct packed {
    logic              valid;
    logic signed [9:0] x0;
    logic signed [9:0] y0;
    logic [7:0]        fx;
    logic [7:0]        fy;
  } samp_req_t;

endpackage

// ===== hw/rtl/twbr_disp.sv =====
// ----------------------------------------------------------------------------
// twbr_disp
// Scan time, segment lookup in the control point memory and displacement
// interpolation; produces the integer sample position and fractions.
// ----------------------------------------------------------------------------
module twbr_disp (
  input  logic                 clk,
  input  logic                 rst,
  input  twbr_pkg::cfg_t       cfg,
  input  logic                 query,
  input  logic                 pt_we,
  input  logic [4:0]           point_index,
  input  logic [31:0]          pt_data,
  input  logic [7:0]           pos_x,
  input  logic [7:0]           pos_y,
  output twbr_pkg::samp_req_t  req
);
  import twbr_pkg::*;

  logic [31:0] pts_a [MaxPoints];
  logic [31:0] pts_b [MaxPoints];
  logic [MaxPoints-1:0] pt_valid;

  logic [8:0]  w, h;
  logic [6:0]  n;
  logic        in_frame;
  logic [7:0]  xt;

  // stage 1: products
  logic        s1_v, s1_in;
  logic [7:0]  s1_x, s1_y;
  logic [40:0] s1_ty, s1_tx;
  // stage 2: segment and memory read
  logic        s2_v, s2_in;
  logic [7:0]  s2_x, s2_y;
  logic [16:0] s2_f;
  logic        s2_va, s2_vb;
  logic [31:0] s2_a, s2_b;
  logic [41:0] t_sum;
  logic [25:0] seg_full;
  logic [PW-1:0] seg_c, seg_n;
  logic [16:0] f_c;
  // stage 3: interpolation products
  logic        s3_v, s3_in;
  logic [7:0]  s3_x, s3_y;
  logic signed [33:0] s3_px0, s3_px1, s3_py0, s3_py1;
  logic signed [15:0] ax, ay, bx, by;
  logic signed [17:0] g1, g0;
  logic signed [35:0] sx, sy;
  logic signed [19:0] dxq, dyq;
  logic signed [20:0] locx, locy;

  always_comb begin
    w = (cfg.width == 9'd0) ? 9'd1 :
        ((cfg.width > 9'(MaxWidth)) ? 9'(MaxWidth) : cfg.width);
    h = (cfg.height == 9'd0) ? 9'd1 :
        ((cfg.height > 9'(MaxHeight)) ? 9'(MaxHeight) : cfg.height);
    if (cfg.point_count < 6'd2) begin
      n = 7'd2;
    end else if ({1'b0, cfg.point_count} > 7'(MaxPoints)) begin
      n = 7'(MaxPoints);
    end else begin
      n = {1'b0, cfg.point_count};
    end
    in_frame = ({1'b0, pos_x} < w) && ({1'b0, pos_y} < h);
    xt = (cfg.bidir && pos_y[0]) ? 8'(w - 9'd1 - {1'b0, pos_x}) : pos_x;
  end

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pts_a[point_index] <= pt_data;
      pts_b[point_index] <= pt_data;
    end
    if (rst) begin
      pt_valid <= '0;
    end else if (pt_we) begin
      pt_valid[point_index] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s1_v <= query;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_in <= in_frame;
    s1_x  <= pos_x;
    s1_y  <= pos_y;
    s1_ty <= 41'(pos_y * cfg.line_step);
    s1_tx <= 41'(xt * cfg.pixel_step);
  end

  always_comb begin
    t_sum    = {1'b0, s1_ty} + {1'b0, s1_tx};
    seg_full = t_sum[41:16];
    if (seg_full >= 26'(n - 7'd1)) begin
      seg_c = PW'(n - 7'd2);
      f_c   = 17'h10000;
    end else begin
      seg_c = PW'(seg_full);
      f_c   = {1'b0, t_sum[15:0]};
    end
    seg_n = seg_c + PW'(1);
  end

  always_ff @(posedge clk) begin
    s2_in  <= s1_in;
    s2_x   <= s1_x;
    s2_y   <= s1_y;
    s2_f   <= f_c;
    s2_a   <= pts_a[seg_c];
    s2_b   <= pts_b[seg_n];
    s2_va  <= pt_valid[seg_c];
    s2_vb  <= pt_valid[seg_n];
  end

  always_comb begin
    ax = (s2_va && s2_in) ? s2_a[15:0]  : '0;
    ay = (s2_va && s2_in) ? s2_a[31:16] : '0;
    bx = (s2_vb && s2_in) ? s2_b[15:0]  : '0;
    by = (s2_vb && s2_in) ? s2_b[31:16] : '0;
    g1 = $signed({1'b0, s2_f});
    g0 = 18'sh10000 - g1;
  end

  always_ff @(posedge clk) begin
    s3_in  <= s2_in;
    s3_x   <= s2_x;
    s3_y   <= s2_y;
    s3_px0 <= 34'(ax * g0);
    s3_px1 <= 34'(bx * g1);
    s3_py0 <= 34'(ay * g0);
    s3_py1 <= 34'(by * g1);
  end

  always_comb begin
    sx   = 36'(s3_px0) + 36'(s3_px1) + 36'sd32768;
    sy   = 36'(s3_py0) + 36'(s3_py1) + 36'sd32768;
    dxq  = 20'(sx >>> 16);
    dyq  = 20'(sy >>> 16);
    locx = $signed({5'd0, s3_x, 8'd0}) + 21'(dxq);
    locy = $signed({5'd0, s3_y, 8'd0}) + 21'(dyq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      req.valid <= s3_v;
    end
    req.x0 <= 10'(locx >>> 8);
    req.y0 <= 10'(locy >>> 8);
    req.fx <= locx[7:0];
    req.fy <= locy[7:0];
  end

endmodule

// ===== hw/rtl/twbr_sample.sv =====
// ----------------------------------------------------------------------------
// twbr_sample
// Frame store in four banks by row and column parity, so the four
// neighbours are read in the same cycle, and the bilinear weighting.
// ----------------------------------------------------------------------------
module twbr_sample (
  input  logic                 clk,
  input  logic                 rst,
  input  twbr_pkg::cfg_t       cfg,
  input  logic                 px_we,
  input  logic [7:0]           pos_x,
  input  logic [7:0]           pos_y,
  input  logic [15:0]          pixel_in,
  input  twbr_pkg::samp_req_t  req,
  output logic                 strobe,
  output logic signed [24:0]   warped_value,
  output logic                 inside_res
);
  import twbr_pkg::*;

  logic [15:0] bank0 [BankDepth];
  logic [15:0] bank1 [BankDepth];
  logic [15:0] bank2 [BankDepth];
  logic [15:0] bank3 [BankDepth];

  logic [8:0]  w, h;
  logic        nb_in;
  logic [7:0]  x0, y0, x1, y1;
  logic [7:0]  xe, xo, ye, yo;
  logic [BankAw-1:0] a_ee, a_eo, a_oe, a_oo, wa;
  logic [1:0]  wb;

  // pixel writes delayed to line up with the query read stage
  logic [3:0]        wr_v;
  logic [BankAw-1:0] wr_a [4];
  logic [1:0]        wr_b [4];
  logic [15:0]       wr_d [4];

  logic        r_v, r_in, r_xp, r_yp;
  logic [7:0]  r_fx, r_fy;
  logic [15:0] q_ee, q_eo, q_oe, q_oo;
  logic [15:0] p00, p01, p10, p11;
  logic [8:0]  ux, uy, vx, vy;

  logic        m_v, m_in;
  logic [24:0] m_t0, m_t1;
  logic [8:0]  m_uy, m_vy;

  logic        n_v, n_in;
  logic [33:0] n_s0, n_s1;
  logic [34:0] total;

  always_comb begin
    w = (cfg.width == 9'd0) ? 9'd1 :
        ((cfg.width > 9'(MaxWidth)) ? 9'(MaxWidth) : cfg.width);
    h = (cfg.height == 9'd0) ? 9'd1 :
        ((cfg.height > 9'(MaxHeight)) ? 9'(MaxHeight) : cfg.height);
    nb_in = !req.x0[9] && !req.y0[9] &&
            (11'($signed(req.x0)) + 11'sd1 < $signed({2'b0, w})) &&
            (11'($signed(req.y0)) + 11'sd1 < $signed({2'b0, h}));
    x0 = req.x0[7:0];
    y0 = req.y0[7:0];
    x1 = x0 + 8'd1;
    y1 = y0 + 8'd1;
    xe = x0[0] ? x1 : x0;
    xo = x0[0] ? x0 : x1;
    ye = y0[0] ? y1 : y0;
    yo = y0[0] ? y0 : y1;
    a_ee = {ye[7:1], xe[7:1]};
    a_eo = {ye[7:1], xo[7:1]};
    a_oe = {yo[7:1], xe[7:1]};
    a_oo = {yo[7:1], xo[7:1]};
    wa   = {pos_y[7:1], pos_x[7:1]};
    wb   = {pos_y[0], pos_x[0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_v <= '0;
    end else begin
      wr_v <= {wr_v[2:0], px_we};
    end
  end

  always_ff @(posedge clk) begin
    wr_a[0] <= wa;
    wr_b[0] <= wb;
    wr_d[0] <= pixel_in;
    wr_a[1] <= wr_a[0];
    wr_b[1] <= wr_b[0];
    wr_d[1] <= wr_d[0];
    wr_a[2] <= wr_a[1];
    wr_b[2] <= wr_b[1];
    wr_d[2] <= wr_d[1];
    wr_a[3] <= wr_a[2];
    wr_b[3] <= wr_b[2];
    wr_d[3] <= wr_d[2];
  end

  always_ff @(posedge clk) begin
    if (wr_v[3] && wr_b[3] == 2'd0) bank0[wr_a[3]] <= wr_d[3];
    if (wr_v[3] && wr_b[3] == 2'd1) bank1[wr_a[3]] <= wr_d[3];
    if (wr_v[3] && wr_b[3] == 2'd2) bank2[wr_a[3]] <= wr_d[3];
    if (wr_v[3] && wr_b[3] == 2'd3) bank3[wr_a[3]] <= wr_d[3];
    q_ee <= bank0[a_ee];
    q_eo <= bank1[a_eo];
    q_oe <= bank2[a_oe];
    q_oo <= bank3[a_oo];
  end

  always_ff @(posedge clk) begin
    r_in <= nb_in;
    r_xp <= x0[0];
    r_yp <= y0[0];
    r_fx <= req.fx;
    r_fy <= req.fy;
  end

  always_comb begin
    p00 = r_yp ? (r_xp ? q_oo : q_oe) : (r_xp ? q_eo : q_ee);
    p01 = r_yp ? (r_xp ? q_oe : q_oo) : (r_xp ? q_ee : q_eo);
    p10 = r_yp ? (r_xp ? q_eo : q_ee) : (r_xp ? q_oo : q_oe);
    p11 = r_yp ? (r_xp ? q_ee : q_eo) : (r_xp ? q_oe : q_oo);
    ux = {1'b0, r_fx};
    uy = {1'b0, r_fy};
    vx = 9'd256 - ux;
    vy = 9'd256 - uy;
  end

  // horizontal blend per row, then vertical blend
  always_ff @(posedge clk) begin
    m_in <= r_in;
    m_t0 <= 25'(p00 * vx) + 25'(p01 * ux);
    m_t1 <= 25'(p10 * vx) + 25'(p11 * ux);
    m_uy <= uy;
    m_vy <= vy;
    n_in <= m_in;
    n_s0 <= 34'(m_t0 * m_vy);
    n_s1 <= 34'(m_t1 * m_uy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_v <= 1'b0;
      m_v <= 1'b0;
      n_v <= 1'b0;
      strobe <= 1'b0;
    end else begin
      r_v <= req.valid;
      m_v <= r_v;
      n_v <= m_v;
      strobe <= n_v;
    end
  end

  assign total = {1'b0, n_s0} + {1'b0, n_s1} + 35'd128;

  always_ff @(posedge clk) begin
    inside_res <= n_in;
    if (n_in) begin
      warped_value <= $signed(total[32:8]);
    end else begin
      warped_value <= cfg.fill ? -25'sd1 : 25'sd0;
    end
  end

endmodule

// ===== hw/rtl/time_warp_bilinear_resampler_core.sv =====
// ----------------------------------------------------------------------------
// time_warp_bilinear_resampler_core
// Scanned-image motion warp: displacement from control points, then a
// bilinear sample of the frame store.
// ----------------------------------------------------------------------------
// usage
//   a word is taken on start (busy is always low); op selects a pixel
//   write, a control point write or a query
//   writes give no result; a query gives one result word on strobe with
//   warped_value and inside_res
//   one word per cycle, sustained; queries are pipelined through the
//   control point memory read, interpolation and the four-bank frame
//   store read, one bank per neighbour parity
//   a query sees every write taken before it
//   reset returns registers to defaults and control points to zero;
//   the frame store is not cleared and reads of unwritten pixels are
//   undefined
//   results cannot be held off: strobe is high for one cycle per result
//   configuration is written with cfg_we, cfg_index and cfg_data
// ----------------------------------------------------------------------------
module time_warp_bilinear_resampler_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op,
  input  logic [7:0]         pos_x,
  input  logic [7:0]         pos_y,
  input  logic [15:0]        pixel_in,
  input  logic [4:0]         point_index,
  input  logic signed [15:0] disp_x,
  input  logic signed [15:0] disp_y,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               strobe,
  output logic signed [24:0] warped_value,
  output logic               inside_res
);
  import twbr_pkg::*;

  cfg_t      cfg;
  samp_req_t req;
  logic      take;

  assign busy = 1'b0;
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width       <= 9'd256;
      cfg.height      <= 9'd256;
      cfg.pixel_step  <= '0;
      cfg.line_step   <= '0;
      cfg.point_count <= 6'd2;
      cfg.bidir       <= 1'b0;
      cfg.fill        <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_t'(cfg_index))
        REG_WIDTH:  cfg.width       <= cfg_data[8:0];
        REG_HEIGHT: cfg.height      <= cfg_data[8:0];
        REG_PSTEP:  cfg.pixel_step  <= cfg_data;
        REG_LSTEP:  cfg.line_step   <= cfg_data;
        REG_NPTS:   cfg.point_count <= cfg_data[5:0];
        REG_BIDIR:  cfg.bidir       <= cfg_data[0];
        REG_FILL:   cfg.fill        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  twbr_disp u_disp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .query       (take && op == OP_QUERY),
    .pt_we       (take && op == OP_WR_POINT),
    .point_index (point_index),
    .pt_data     ({disp_y, disp_x}),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .req         (req)
  );

  twbr_sample u_sample (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .px_we        (take && op == OP_WR_PIXEL),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pixel_in     (pixel_in),
    .req          (req),
    .strobe       (strobe),
    .warped_value (warped_value),
    .inside_res   (inside_res)
  );

endmodule

// ===== test/time_warp_bilinear_resampler_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// time_warp_bilinear_resampler_core_tb
// Drives pixel writes, control point writes and queries through several
// register settings and checks every query result against a behavioral
// prediction of the displacement and bilinear sample.
// ----------------------------------------------------------------------------
module time_warp_bilinear_resampler_core_tb;
  import twbr_pkg::*;

  localparam int LIMIT = 600000;

  typedef struct {
    logic [24:0] value;
    logic        ins;
  } warp_res_t;

  class warp_scoreboard;
    logic [15:0] pix [65536];
    bit          written [65536];
    logic [31:0] pts [32];
    longint      width, height, pstep, lstep, npts, bidir, fill;
    warp_res_t   pending_q [$];
    int          errors;

    function void reset_state();
      for (int i = 0; i < 32; i++) pts[i] = '0;
      width = 256; height = 256; pstep = 0; lstep = 0; npts = 2; bidir = 0; fill = 0;
    endfunction

    function void write_reg(reg_t idx, logic [31:0] data);
      case (idx)
        REG_WIDTH:  width = data[8:0];
        REG_HEIGHT: height = data[8:0];
        REG_PSTEP:  pstep = data;
        REG_LSTEP:  lstep = data;
        REG_NPTS:   npts = data[5:0];
        REG_BIDIR:  bidir = data[0];
        REG_FILL:   fill = data[0];
        default: ;
      endcase
    endfunction

    function longint eff_w();
      return width < 1 ? 1 : (width > MaxWidth ? MaxWidth : width);
    endfunction

    function longint eff_h();
      return height < 1 ? 1 : (height > MaxHeight ? MaxHeight : height);
    endfunction

    // sample origin and fraction after displacement
    function void locate(int px, int py, output longint x0, output longint y0,
                         output longint fx, output longint fy, output bit ins);
      longint w, h, n, xt, seg, f, dxq, dyq, lx, ly;
      longint unsigned t;
      w = eff_w(); h = eff_h();
      n = npts < 2 ? 2 : (npts > MaxPoints ? MaxPoints : npts);
      dxq = 0; dyq = 0;
      if (px < w && py < h) begin
        xt = (bidir != 0 && py[0]) ? (w - 1 - px) : px;
        t = longint'(py) * lstep + xt * pstep;
        seg = longint'(t >> 16);
        f = longint'(t & 64'hFFFF);
        if (t >> 16 >= n - 1) begin
          seg = n - 2;
          f = 65536;
        end
        dxq = (longint'($signed(pts[seg][15:0])) * (65536 - f)
               + longint'($signed(pts[seg+1][15:0])) * f + 32768) >>> 16;
        dyq = (longint'($signed(pts[seg][31:16])) * (65536 - f)
               + longint'($signed(pts[seg+1][31:16])) * f + 32768) >>> 16;
      end
      lx = longint'(px) * 256 + dxq;
      ly = longint'(py) * 256 + dyq;
      x0 = lx >>> 8;
      y0 = ly >>> 8;
      fx = lx - x0 * 256;
      fy = ly - y0 * 256;
      ins = x0 >= 0 && x0 + 1 < w && y0 >= 0 && y0 + 1 < h;
    endfunction

    function void note_word(op_t op, int px, int py, logic [15:0] pin, int idx,
                            logic [15:0] dx, logic [15:0] dy);
      longint x0, y0, fx, fy, base;
      longint unsigned sum;
      bit ins;
      warp_res_t r;
      case (op)
        OP_WR_PIXEL: begin
          pix[py * MaxWidth + px] = pin;
          written[py * MaxWidth + px] = 1;
        end
        OP_WR_POINT: pts[idx] = {dy, dx};
        OP_QUERY: begin
          locate(px, py, x0, y0, fx, fy, ins);
          if (ins) begin
            base = y0 * MaxWidth + x0;
            sum = pix[base] * (256 - fy) * (256 - fx)
                + pix[base + MaxWidth] * fy * (256 - fx)
                + pix[base + 1] * (256 - fy) * fx
                + pix[base + MaxWidth + 1] * fy * fx;
            r.value = 25'((sum + 128) >> 8);
          end else begin
            r.value = fill != 0 ? '1 : '0;
          end
          r.ins = ins;
          pending_q.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [24:0] value, logic ins);
      warp_res_t e;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result value=%h inside=%b", value, ins);
        return;
      end
      e = pending_q.pop_front();
      if (value !== e.value || ins !== e.ins) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected value=%h inside=%b, got value=%h inside=%b",
                   e.value, e.ins, value, ins);
      end
    endfunction
  endclass

  logic              clk = 0;
  logic              rst;
  logic              start;
  logic              busy;
  logic [1:0]        op;
  logic [7:0]        pos_x, pos_y;
  logic [15:0]       pixel_in;
  logic [4:0]        point_index;
  logic signed [15:0] disp_x, disp_y;
  logic              cfg_we;
  logic [2:0]        cfg_index;
  logic [31:0]       cfg_data;
  logic              strobe;
  logic signed [24:0] warped_value;
  logic              inside_res;

  warp_scoreboard sb = new();
  int  cycles = 0;
  bit  allow_gaps = 1;

  time_warp_bilinear_resampler_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .pos_x(pos_x),
    .pos_y(pos_y), .pixel_in(pixel_in), .point_index(point_index), .disp_x(disp_x),
    .disp_y(disp_y), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .strobe(strobe), .warped_value(warped_value), .inside_res(inside_res)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && strobe) sb.check_result(warped_value, inside_res);

  task automatic send_word(op_t o, int px, int py, logic [15:0] pin, int idx,
                           logic [15:0] dx, logic [15:0] dy);
    if (allow_gaps && $urandom_range(0, 5) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    start <= 1; op <= o; pos_x <= px; pos_y <= py; pixel_in <= pin;
    point_index <= idx; disp_x <= dx; disp_y <= dy;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_word(o, px, py, pin, idx, dx, dy);
  endtask

  task automatic write_pixel(int px, int py, logic [15:0] v);
    send_word(OP_WR_PIXEL, px, py, v, $urandom_range(0, 31), $urandom, $urandom);
  endtask

  task automatic write_point(int idx, logic [15:0] dx, logic [15:0] dy);
    send_word(OP_WR_POINT, $urandom_range(0, 255), $urandom_range(0, 255), $urandom,
              idx, dx, dy);
  endtask

  // fill any unwritten neighbour first so a query never reads an empty pixel
  task automatic query(int px, int py);
    longint x0, y0, fx, fy;
    bit ins;
    sb.locate(px, py, x0, y0, fx, fy, ins);
    if (ins)
      for (int j = 0; j < 2; j++)
        for (int i = 0; i < 2; i++)
          if (!sb.written[(y0 + j) * MaxWidth + x0 + i])
            write_pixel(int'(x0 + i), int'(y0 + j), $urandom);
    send_word(OP_QUERY, px, py, $urandom, $urandom_range(0, 31), $urandom, $urandom);
  endtask

  task automatic drain();
    start <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(reg_t idx, logic [31:0] data);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= data;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, data);
  endtask

  task automatic configure(int phase);
    logic [31:0] w, h, n, ls;
    case (phase)
      1: begin w = 8; h = 8; n = 2; end
      2: begin w = 1; h = 3; n = 32; end
      3: begin w = 0; h = 511; n = 0; end
      4: begin w = 256; h = 256; n = 63; end
      default: begin
        w = $urandom_range(6, 24); h = $urandom_range(6, 24); n = $urandom_range(2, 32);
      end
    endcase
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_NPTS, n);
    if (phase == 4) begin
      write_reg(REG_PSTEP, 32'hFFFF_FFFF);
      write_reg(REG_LSTEP, 32'hFFFF_FFFF);
    end else begin
      ls = 32'((longint'(sb.npts < 2 ? 2 : (sb.npts > 32 ? 32 : sb.npts)) - 1) * 65536
               / sb.eff_h()) + $urandom_range(0, 300);
      write_reg(REG_LSTEP, ls);
      write_reg(REG_PSTEP, ls / sb.eff_w() + $urandom_range(0, 50));
    end
    write_reg(REG_BIDIR, phase[0]);
    write_reg(REG_FILL, phase % 3 == 1);
    write_reg(REG_SPARE, $urandom);
  endtask

  task automatic random_item();
    int  sel, w, h;
    longint span;
    w = int'(sb.eff_w()); h = int'(sb.eff_h());
    span = 3 * 256;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      send_word(OP_NONE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (sel < 22) begin
      write_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom);
    end else if (sel < 32) begin
      if ($urandom_range(0, 9) == 0)
        write_point($urandom_range(0, 31), $urandom, $urandom);
      else
        write_point($urandom_range(0, 31), 16'($urandom_range(0, 2 * span) - span),
                    16'($urandom_range(0, 2 * span) - span));
    end else if (sel < 40) begin
      query($urandom_range(0, 255), $urandom_range(0, 255));
    end else begin
      query($urandom_range(0, w > 254 ? 255 : w + 1), $urandom_range(0, h > 254 ? 255 : h + 1));
    end
  endtask

  initial begin
    rst = 1; start = 0; op = OP_NONE; pos_x = 0; pos_y = 0; pixel_in = 0;
    point_index = 0; disp_x = 0; disp_y = 0; cfg_we = 0; cfg_index = REG_WIDTH;
    cfg_data = 0;
    sb.reset_state();
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // defaults: full frame, zero steps, two points
    write_pixel(0, 0, 16'h0000);
    write_pixel(1, 0, 16'hFFFF);
    write_pixel(0, 1, 16'h8001);
    write_pixel(1, 1, 16'h7FFE);
    query(0, 0);
    write_point(0, 16'h0080, 16'h0080);
    query(0, 0);
    write_point(0, 16'h8000, 16'h7FFF);
    write_point(1, 16'h7FFF, 16'h8000);
    query(0, 0);
    write_point(0, 16'hFFFF, 16'h0000);
    write_point(1, 16'h0000, 16'h0000);
    query(1, 0);
    write_point(0, 16'h0000, 16'h0000);
    write_point(31, 16'h7FFF, 16'h8000);
    query(254, 254);
    query(255, 255);
    query(255, 0);
    query(0, 255);
    send_word(OP_NONE, 0, 0, 0, 0, 0, 0);
    write_pixel(255, 255, 16'hFFFF);
    query(255, 255);
    drain();

    for (int phase = 1; phase <= 8; phase++) begin
      configure(phase);
      if (phase == 8) allow_gaps = 0;
      repeat (230) random_item();
      drain();
    end

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
